>>> hdl/omw_pkg.sv
// ----------------------------------------------------------------------------
// omw_pkg: shared types and constants of the OSC message writer
// Function codes, status codes, phase encoding, tag codes and the control
// and result structures passed between the writer's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package omw_pkg;

  // Default depth of the tag store.
  localparam int MAX_TAGS_DEF = 16;

  // Configuration port geometry and register map.
  localparam int          CFG_AW       = 3;
  localparam logic [0:0]  REG_CAPACITY = 1'b0;
  localparam logic [15:0] CAP_RESET    = 16'd1024;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;

  // Stored tag codes.
  localparam logic [1:0] TAG_S = 2'd0;
  localparam logic [1:0] TAG_F = 2'd1;
  localparam logic [1:0] TAG_I = 2'd2;

  typedef enum logic [2:0] {
    FN_ADDR  = 3'd0,
    FN_TAG   = 3'd1,
    FN_SARG  = 3'd2,
    FN_FLOAT = 3'd3,
    FN_INT   = 3'd4,
    FN_END   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_NO_COMMA = 3'd2,
    ST_BAD_TAG  = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_ORDER    = 3'd5,
    ST_TAGS     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_TAGS = 2'd1,
    PH_ARGS = 2'd2,
    PH_SARG = 2'd3
  } phase_t;

  // Message state that does not depend on the tag store depth.
  typedef struct packed {
    phase_t      phase;
    logic        comma;
    logic [1:0]  mod4;
    status_t     err;
    logic [15:0] total;
  } msg_ctl_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        done;
    status_t     status;
    logic [15:0] length;
  } omw_res_t;

endpackage

`default_nettype wire

>>> hdl/omw_ram.sv
// ----------------------------------------------------------------------------
// omw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and shows
// the contents before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module omw_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/omw_encode.sv
// ----------------------------------------------------------------------------
// omw_encode: per-item encoding step
// Works out the bytes to emit for one transaction, the status and the next
// message state, from the current state and the prefetched next tag.
// ----------------------------------------------------------------------------
`default_nettype none

module omw_encode #(
  parameter int MAX_TAGS = omw_pkg::MAX_TAGS_DEF
) (
  input  wire omw_pkg::func_t                func_i,
  input  wire logic [31:0]                   value_i,
  input  wire logic [15:0]                   cap_i,
  input  wire omw_pkg::msg_ctl_t             ctl_i,
  input  wire logic [$clog2(MAX_TAGS+1)-1:0] tag_total_i,
  input  wire logic [$clog2(MAX_TAGS+1)-1:0] arg_ptr_i,
  input  wire logic [1:0]                    next_tag_i,
  output omw_pkg::msg_ctl_t                  ctl_o,
  output logic      [$clog2(MAX_TAGS+1)-1:0] tag_total_o,
  output logic      [$clog2(MAX_TAGS+1)-1:0] arg_ptr_o,
  output logic                               tag_we_o,
  output logic      [1:0]                    tag_wdata_o,
  output omw_pkg::omw_res_t                  res_o
);

  import omw_pkg::*;

  localparam int CW = $clog2(MAX_TAGS + 1);

  logic [7:0]  ch;
  logic [1:0]  eff_mod4;
  logic [2:0]  pad_n;
  logic [2:0]  em_n;
  logic [31:0] em_word;
  logic        em_req;
  logic        em_is_char;
  logic        em_is_pad;
  logic [16:0] em_sum;
  logic        em_fit;
  logic        has_tag;
  logic        tag_known;
  logic [1:0]  tag_code;
  logic        ok_phase;
  phase_t      ok_phase_val;
  logic        ok_comma;
  logic        ok_tag;
  logic        ok_arg;
  status_t     end_st;

  always_comb begin
    ch       = value_i[7:0];
    // A string argument restarts its length count when it opens.
    eff_mod4 = (func_i == FN_SARG && ctl_i.phase == PH_ARGS) ? 2'd0 : ctl_i.mod4;
    pad_n    = 3'd4 - {1'b0, eff_mod4};
    has_tag  = arg_ptr_i < tag_total_i;

    // Classify a tag character.
    tag_known = 1'b1;
    tag_code  = TAG_S;
    unique case (ch)
      CH_S:    tag_code = TAG_S;
      CH_F:    tag_code = TAG_F;
      CH_I:    tag_code = TAG_I;
      default: tag_known = 1'b0;
    endcase

    // Defaults: hold everything, emit nothing.
    ctl_o        = ctl_i;
    tag_total_o  = tag_total_i;
    arg_ptr_o    = arg_ptr_i;
    tag_we_o     = 1'b0;
    tag_wdata_o  = tag_code;
    res_o        = '0;
    em_req       = 1'b0;
    em_is_char   = 1'b0;
    em_is_pad    = 1'b0;
    em_n         = 3'd0;
    em_word      = '0;
    ok_phase     = 1'b0;
    ok_phase_val = ctl_i.phase;
    ok_comma     = 1'b0;
    ok_tag       = 1'b0;
    ok_arg       = 1'b0;
    end_st       = ctl_i.err;

    if (func_i == FN_END) begin
      // End of message: report, then clear the message state.
      if (ctl_i.err == ST_OK) begin
        if (ctl_i.phase != PH_ARGS) begin
          end_st = ST_ORDER;
        end else if (arg_ptr_i != tag_total_i) begin
          end_st = ST_MISMATCH;
        end
      end
      ctl_o.phase = PH_ADDR;
      ctl_o.comma = 1'b0;
      ctl_o.mod4  = 2'd0;
      ctl_o.err   = ST_OK;
      ctl_o.total = '0;
      tag_total_o = '0;
      arg_ptr_o   = '0;
    end else if (ctl_i.err == ST_OK) begin
      // Decide what the item asks to emit.
      unique case (func_i)
        FN_ADDR: begin
          if (ctl_i.phase != PH_ADDR) begin
            ctl_o.err = ST_ORDER;
          end else if (ch != CH_NUL) begin
            em_is_char = 1'b1;
          end else begin
            em_is_pad    = 1'b1;
            ok_phase     = 1'b1;
            ok_phase_val = PH_TAGS;
          end
        end
        FN_TAG: begin
          if (ctl_i.phase != PH_TAGS) begin
            ctl_o.err = ST_ORDER;
          end else if (!ctl_i.comma) begin
            if (ch != CH_COMMA) begin
              ctl_o.err = ST_NO_COMMA;
            end else begin
              em_is_char = 1'b1;
              ok_comma   = 1'b1;
            end
          end else if (ch == CH_NUL) begin
            em_is_pad    = 1'b1;
            ok_phase     = 1'b1;
            ok_phase_val = PH_ARGS;
          end else if (!tag_known) begin
            ctl_o.err = ST_BAD_TAG;
          end else if (tag_total_i >= CW'(MAX_TAGS)) begin
            ctl_o.err = ST_TAGS;
          end else begin
            em_is_char = 1'b1;
            ok_tag     = 1'b1;
          end
        end
        FN_SARG: begin
          if (ctl_i.phase == PH_ADDR || ctl_i.phase == PH_TAGS) begin
            ctl_o.err = ST_ORDER;
          end else if (ctl_i.phase == PH_ARGS && !(has_tag && next_tag_i == TAG_S)) begin
            ctl_o.err = ST_MISMATCH;
          end else begin
            // The string argument is open from here on, emitted or not.
            ctl_o.phase = PH_SARG;
            ctl_o.mod4  = eff_mod4;
            if (ch != CH_NUL) begin
              em_is_char = 1'b1;
            end else begin
              em_is_pad    = 1'b1;
              ok_phase     = 1'b1;
              ok_phase_val = PH_ARGS;
              ok_arg       = 1'b1;
            end
          end
        end
        FN_FLOAT, FN_INT: begin
          if (ctl_i.phase != PH_ARGS) begin
            ctl_o.err = ST_ORDER;
          end else if (!(has_tag &&
                         next_tag_i == ((func_i == FN_FLOAT) ? TAG_F : TAG_I))) begin
            ctl_o.err = ST_MISMATCH;
          end else begin
            em_req  = 1'b1;
            em_n    = 3'd4;
            em_word = value_i;
            ok_arg  = 1'b1;
          end
        end
        default: begin
          ctl_o.err = ST_ORDER;
        end
      endcase

      if (em_is_char) begin
        em_req  = 1'b1;
        em_n    = 3'd1;
        em_word = {ch, 24'd0};
      end else if (em_is_pad) begin
        em_req  = 1'b1;
        em_n    = pad_n;
        em_word = '0;
      end
    end

    // Capacity check and commit of the emission.
    em_sum = {1'b0, ctl_i.total} + {14'd0, em_n};
    em_fit = em_sum <= {1'b0, cap_i};
    if (em_req) begin
      if (!em_fit) begin
        ctl_o.err = ST_OVERFLOW;
      end else begin
        ctl_o.total = em_sum[15:0];
        res_o.word  = em_word;
        res_o.count = em_n;
        if (em_is_char) begin
          ctl_o.mod4 = eff_mod4 + 2'd1;
        end else if (em_is_pad) begin
          ctl_o.mod4 = 2'd0;
        end
        if (ok_phase) begin
          ctl_o.phase = ok_phase_val;
        end
        if (ok_comma) begin
          ctl_o.comma = 1'b1;
        end
        if (ok_tag) begin
          tag_we_o    = 1'b1;
          tag_total_o = tag_total_i + CW'(1);
        end
        if (ok_arg) begin
          arg_ptr_o = arg_ptr_i + CW'(1);
        end
      end
    end

    // Result fields.
    if (func_i == FN_END) begin
      res_o.done   = 1'b1;
      res_o.status = end_st;
      res_o.length = ctl_i.total;
    end else begin
      res_o.status = ctl_o.err;
      res_o.length = ctl_o.total;
    end
  end

endmodule

`default_nettype wire

>>> hdl/osc_message_writer_core.sv
// ----------------------------------------------------------------------------
// osc_message_writer_core: streaming OSC 1.0 message writer
// Takes address characters, tag characters and arguments one transaction at
// a time and returns the bytes to put on the wire, with status and length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, in_func, in_value) carries one item per
//   transaction; the output channel (out_valid/out_stall) returns exactly one
//   result per item: up to four packed bytes, their count, and on the end
//   item the done flag, the final status and the message length.
//   The APB port holds capacity_bytes at byte address 0; write it only while
//   no message item is in flight.
// Pipeline and throughput:
//   An accepted item is captured in the input register, encoded, and its
//   result captured in the result register once that register is free. One
//   item is taken every cycle while the result channel is not stalled; the
//   rate is set by the single encoding step between the two registers.
//   The tag store is a small RAM whose next entry is prefetched each cycle.
// Reset and stall:
//   rst_n (synchronous, active low) empties both registers, returns the
//   message state to the address phase and sets capacity to 1024. There is
//   no clearing pass. While out_stall is high with a result waiting, the
//   input register fills once and then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_message_writer_core #(
  parameter int MAX_TAGS = omw_pkg::MAX_TAGS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_func,
  input  wire logic [31:0]                 in_value,
  // Result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [31:0]                 out_word,
  output logic      [2:0]                  out_byte_count,
  output logic                             out_done_res,
  output logic      [2:0]                  out_status,
  output logic      [15:0]                 out_msg_length,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [omw_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  import omw_pkg::*;

  localparam int CW = $clog2(MAX_TAGS + 1);
  localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

  // Input register
  logic        in_v_r;
  func_t       func_r;
  logic [31:0] value_r;

  // Result register
  logic     out_v_r;
  omw_res_t res_r;

  // Message state
  msg_ctl_t        ctl_r;
  msg_ctl_t        ctl_nxt;
  logic [CW-1:0]   tag_total_r;
  logic [CW-1:0]   tag_total_nxt;
  logic [CW-1:0]   arg_ptr_r;
  logic [CW-1:0]   arg_ptr_nxt;
  logic [15:0]     cap_r;

  // Tag store access
  logic          tag_we;
  logic [1:0]    tag_wdata;
  logic [AW-1:0] tag_waddr;
  logic [AW-1:0] tag_raddr;
  logic [1:0]    tag_rdata;
  logic          byp_v_r;
  logic [1:0]    byp_d_r;
  logic [1:0]    next_tag;

  omw_res_t res;
  logic     advance;
  logic     cfg_wr;

  // Handshake: the item in the input register moves on when the result
  // register is empty or being taken.
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      func_r  <= func_t'(in_func);
      value_r <= in_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  // Encoding step
  omw_encode #(
    .MAX_TAGS (MAX_TAGS)
  ) u_encode (
    .func_i      (func_r),
    .value_i     (value_r),
    .cap_i       (cap_r),
    .ctl_i       (ctl_r),
    .tag_total_i (tag_total_r),
    .arg_ptr_i   (arg_ptr_r),
    .next_tag_i  (next_tag),
    .ctl_o       (ctl_nxt),
    .tag_total_o (tag_total_nxt),
    .arg_ptr_o   (arg_ptr_nxt),
    .tag_we_o    (tag_we),
    .tag_wdata_o (tag_wdata),
    .res_o       (res)
  );

  // Message state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase <= PH_ADDR;
      ctl_r.comma <= 1'b0;
      ctl_r.mod4  <= 2'd0;
      ctl_r.err   <= ST_OK;
      ctl_r.total <= '0;
      tag_total_r <= '0;
      arg_ptr_r   <= '0;
    end else if (advance) begin
      ctl_r       <= ctl_nxt;
      tag_total_r <= tag_total_nxt;
      arg_ptr_r   <= arg_ptr_nxt;
    end
  end

  // Tag store: written at the tag count, read ahead at the argument
  // pointer so the next expected tag is ready for the following item.
  assign tag_waddr = tag_total_r[AW-1:0];
  assign tag_raddr = advance ? arg_ptr_nxt[AW-1:0] : arg_ptr_r[AW-1:0];

  omw_ram #(
    .WIDTH (2),
    .DEPTH (MAX_TAGS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (advance && tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // Forward a tag written to the entry being read in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else begin
      byp_v_r <= advance && tag_we && (tag_waddr == tag_raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_d_r <= tag_wdata;
  end

  assign next_tag = byp_v_r ? byp_d_r : tag_rdata;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2:2] == REG_CAPACITY) ? {16'd0, cap_r} : 32'd0;

  // Result ports
  assign out_valid      = out_v_r;
  assign out_word       = res_r.word;
  assign out_byte_count = res_r.count;
  assign out_done_res   = res_r.done;
  assign out_status     = res_r.status;
  assign out_msg_length = res_r.length;

endmodule

`default_nettype wire

>>> hdl/omw_checker.sv
// ----------------------------------------------------------------------------
// omw_checker: port-level checks for the OSC message writer
// Watches the top level's ports and flags results that the encoder could
// never legally produce; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module omw_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [31:0]                 out_word,
  input wire logic [2:0]                  out_byte_count,
  input wire logic                        out_done_res,
  input wire logic [2:0]                  out_status,
  input wire logic [15:0]                 out_msg_length
);

  import omw_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending straight after reset");

  // The end-of-message transaction carries no bytes.
  a_end_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_byte_count == 3'd0)
    else $error("end transaction carries bytes");

  // Bytes are only emitted while the message is free of errors.
  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count != 3'd0 |-> out_status == ST_OK && !out_done_res)
    else $error("bytes emitted with an error status");

  // A word never holds more than four bytes.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count <= 3'd4)
    else $error("byte count out of range");

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word) &&
                               $stable(out_msg_length))
    else $error("stalled result changed");

endmodule

bind osc_message_writer_core omw_checker u_omw_checker (.*);

`default_nettype wire

>>> sim/omw_stream_checker.sv
// ----------------------------------------------------------------------------
// omw_stream_checker: result checker for the OSC message writer
// Watches the item channel, the result channel and the APB port of the
// writer. It keeps its own model of the encoder and computes the result that
// each accepted item should produce. Every result taken from the writer is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module omw_stream_checker
  import omw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Item channel, as seen by the writer
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [2:0]          in_func,
  input  logic [31:0]         in_value,
  // Result channel
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [31:0]         out_word,
  input  logic [2:0]          out_byte_count,
  input  logic                out_done_res,
  input  logic [2:0]          out_status,
  input  logic [15:0]         out_msg_length,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  // Progress and verdict towards the testbench top
  output int                  results_owed,
  output int                  fault_count
);

  // Model of the message state.
  logic [15:0] capacity;
  phase_t      phase;
  logic [15:0] byte_total;
  logic [1:0]  tag_kinds [MAX_TAGS_DEF];
  logic [4:0]  tag_count;
  logic [4:0]  arg_index;
  logic [1:0]  str_mod4;
  status_t     err_code;
  logic        comma_seen;

  // Bytes produced by the item being encoded.
  logic [31:0] emit_word;
  logic [2:0]  emit_count;

  omw_res_t    owed_results [$];
  int          fail_total;
  int          results_seen;

  initial begin
    results_owed = 0;
    fault_count  = 0;
    fail_total   = 0;
    results_seen = 0;
  end

  function automatic void clear_message();
    phase      = PH_ADDR;
    byte_total = '0;
    tag_count  = '0;
    arg_index  = '0;
    str_mod4   = '0;
    err_code   = ST_OK;
    comma_seen = 1'b0;
  endfunction

  // The first error of a message is the one that is kept.
  function automatic void raise_error(status_t code);
    if (err_code == ST_OK)
      err_code = code;
  endfunction

  // Emits n bytes unless that would exceed the capacity.
  function automatic bit put_bytes(logic [31:0] w, logic [2:0] n);
    if ({1'b0, byte_total} + 17'(n) > {1'b0, capacity}) begin
      raise_error(ST_OVERFLOW);
      return 1'b0;
    end
    byte_total = byte_total + 16'(n);
    emit_word  = w;
    emit_count = n;
    return 1'b1;
  endfunction

  function automatic bit put_char(logic [7:0] c);
    if (!put_bytes({c, 24'h0}, 3'd1))
      return 1'b0;
    str_mod4 = str_mod4 + 2'd1;
    return 1'b1;
  endfunction

  // Zero padding that brings the string to a four-byte boundary.
  function automatic bit put_padding();
    if (!put_bytes(32'h0, 3'd4 - {1'b0, str_mod4}))
      return 1'b0;
    str_mod4 = '0;
    return 1'b1;
  endfunction

  function automatic bit next_tag_is(logic [1:0] code);
    return (arg_index < tag_count) && (arg_index < MAX_TAGS_DEF) &&
           (tag_kinds[arg_index[3:0]] == code);
  endfunction

  // Works out the result of one item and advances the model.
  function automatic omw_res_t encode_item(logic [2:0] f, logic [31:0] v);
    omw_res_t   r;
    logic [7:0] c;
    logic [1:0] code;
    bit         known;
    status_t    st;
    c          = v[7:0];
    emit_word  = '0;
    emit_count = '0;
    code       = TAG_S;
    known      = 1'b1;

    // The end item reports the outcome and starts a fresh message.
    if (f == FN_END) begin
      st = err_code;
      if (st == ST_OK) begin
        if (phase != PH_ARGS)
          st = ST_ORDER;
        else if (arg_index != tag_count)
          st = ST_MISMATCH;
      end
      r.word   = '0;
      r.count  = '0;
      r.done   = 1'b1;
      r.status = st;
      r.length = byte_total;
      clear_message();
      return r;
    end

    if (err_code == ST_OK) begin
      case (f)
        FN_ADDR: begin
          if (phase != PH_ADDR)
            raise_error(ST_ORDER);
          else if (c != CH_NUL)
            void'(put_char(c));
          else if (put_padding())
            phase = PH_TAGS;
        end
        FN_TAG: begin
          if (phase != PH_TAGS) begin
            raise_error(ST_ORDER);
          end else if (!comma_seen) begin
            if (c != CH_COMMA)
              raise_error(ST_NO_COMMA);
            else if (put_char(c))
              comma_seen = 1'b1;
          end else if (c == CH_NUL) begin
            if (put_padding())
              phase = PH_ARGS;
          end else begin
            case (c)
              CH_S:    code = TAG_S;
              CH_F:    code = TAG_F;
              CH_I:    code = TAG_I;
              default: known = 1'b0;
            endcase
            if (!known)
              raise_error(ST_BAD_TAG);
            else if (tag_count >= MAX_TAGS_DEF)
              raise_error(ST_TAGS);
            else if (put_char(c)) begin
              tag_kinds[tag_count[3:0]] = code;
              tag_count = tag_count + 5'd1;
            end
          end
        end
        FN_SARG: begin
          // The first character of a string argument opens it.
          if (phase == PH_ARGS && !next_tag_is(TAG_S)) begin
            raise_error(ST_MISMATCH);
          end else begin
            if (phase == PH_ARGS) begin
              phase    = PH_SARG;
              str_mod4 = '0;
            end
            if (phase != PH_SARG)
              raise_error(ST_ORDER);
            else if (c != CH_NUL)
              void'(put_char(c));
            else if (put_padding()) begin
              phase     = PH_ARGS;
              arg_index = arg_index + 5'd1;
            end
          end
        end
        FN_FLOAT, FN_INT: begin
          if (phase != PH_ARGS)
            raise_error(ST_ORDER);
          else if (!next_tag_is(f == FN_FLOAT ? TAG_F : TAG_I))
            raise_error(ST_MISMATCH);
          else if (put_bytes(v, 3'd4))
            arg_index = arg_index + 5'd1;
        end
        default: raise_error(ST_ORDER);
      endcase
    end

    r.word   = emit_word;
    r.count  = emit_count;
    r.done   = 1'b0;
    r.status = err_code;
    r.length = byte_total;
    return r;
  endfunction

  // Register writes, result comparison and prediction, all at the clock edge.
  always @(posedge clk) begin
    omw_res_t want;
    if (!rst_n) begin
      capacity = CAP_RESET;
      clear_message();
      owed_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_AW-1:2] == REG_CAPACITY)
        capacity = pwdata[15:0];

      // A result is always checked before the item of this edge is added.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          if (fail_total < 10)
            $display("result %0d arrived with no transaction outstanding: word %h",
                     results_seen, out_word);
          fail_total++;
        end else begin
          want = owed_results.pop_front();
          if (out_word !== want.word || out_byte_count !== want.count ||
              out_done_res !== want.done || out_status !== want.status ||
              out_msg_length !== want.length) begin
            if (fail_total < 10) begin
              $display("result %0d: expected word %h count %0d done %0d status %0d length %0d",
                       results_seen, want.word, want.count, want.done, want.status,
                       want.length);
              $display("result %0d: got word %h count %0d done %0d status %0d length %0d",
                       results_seen, out_word, out_byte_count, out_done_res,
                       out_status, out_msg_length);
            end
            fail_total++;
          end
        end
      end

      if (in_valid && !in_stall)
        owed_results.push_back(encode_item(in_func, in_value));
    end
    results_owed <= owed_results.size();
    fault_count  <= fail_total;
  end

endmodule

>>> sim/osc_message_writer_core_tb.sv
// ----------------------------------------------------------------------------
// osc_message_writer_core_tb: testbench of the OSC message writer
// Drives directed and random OSC messages through the writer under several
// capacity settings, with random idling on both channels and long holds of
// the result channel. A checker beside the writer predicts and compares
// every result; this top makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module osc_message_writer_core_tb;
  import omw_pkg::*;

  // Function code that the writer does not define.
  localparam logic [2:0] FN_UNUSED   = 3'd7;
  localparam int         HOLD_CYCLES = 40;
  localparam int         IDLE_LIMIT  = 1000;
  localparam int         ITEM_TARGET = 1200;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func   = '0;
  logic [31:0] in_value  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_word;
  logic [2:0]  out_byte_count;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic [15:0] out_msg_length;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int results_owed;
  int fault_count;
  int items_sent = 0;
  int idle_cycles = 0;

  // Traffic shaping shared by the sender and the receiver.
  bit quiet    = 1'b0;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  osc_message_writer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .out_byte_count (out_byte_count),
    .out_done_res   (out_done_res),
    .out_status     (out_status),
    .out_msg_length (out_msg_length),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  omw_stream_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .out_byte_count (out_byte_count),
    .out_done_res   (out_done_res),
    .out_status     (out_status),
    .out_msg_length (out_msg_length),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .results_owed   (results_owed),
    .fault_count    (fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("osc_message_writer_core: mismatch");
        $finish;
      end
    end
  end

  // Result side: short random stalls, or one long hold when asked for.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // A character in the low byte, with random bits above it.
  function automatic logic [31:0] with_char(logic [7:0] c);
    logic [31:0] v;
    v      = $urandom();
    v[7:0] = c;
    return v;
  endfunction

  function automatic logic [31:0] text_char();
    return with_char(8'($urandom_range(1, 255)));
  endfunction

  // Values that hit the characters the writer treats specially.
  function automatic logic [31:0] noise_value();
    case ($urandom_range(0, 5))
      0:       return with_char(CH_NUL);
      1:       return with_char(CH_COMMA);
      2:       return with_char(CH_S);
      3:       return with_char(CH_F);
      4:       return with_char(CH_I);
      default: return $urandom();
    endcase
  endfunction

  // Offers one item and holds it until the writer takes it.
  task automatic send_item(input logic [2:0] f, input logic [31:0] v);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops offering items and waits for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= {16'h0, cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random message, mostly well formed, now and then damaged.
  task automatic send_message();
    logic [2:0]  fq [$];
    logic [31:0] vq [$];
    logic [1:0]  kinds [$];
    logic [1:0]  kind;
    int          n_addr;
    int          n_tags;
    int          k;

    calm   = ($urandom_range(0, 3) == 0);
    n_addr = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    repeat (n_addr) begin
      fq.push_back(FN_ADDR);
      vq.push_back(text_char());
    end
    fq.push_back(FN_ADDR);
    vq.push_back(with_char(CH_NUL));

    // Tag string, occasionally longer than the tag store.
    fq.push_back(FN_TAG);
    vq.push_back(with_char(CH_COMMA));
    n_tags = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 18) : $urandom_range(0, 6);
    repeat (n_tags) begin
      case ($urandom_range(0, 2))
        0:       kind = TAG_S;
        1:       kind = TAG_F;
        default: kind = TAG_I;
      endcase
      kinds.push_back(kind);
      fq.push_back(FN_TAG);
      vq.push_back(with_char(kind == TAG_S ? CH_S : kind == TAG_F ? CH_F : CH_I));
    end
    fq.push_back(FN_TAG);
    vq.push_back(with_char(CH_NUL));

    // Arguments in tag order.
    foreach (kinds[i]) begin
      case (kinds[i])
        TAG_S: begin
          repeat ($urandom_range(0, 9)) begin
            fq.push_back(FN_SARG);
            vq.push_back(text_char());
          end
          fq.push_back(FN_SARG);
          vq.push_back(with_char(CH_NUL));
        end
        TAG_F: begin
          fq.push_back(FN_FLOAT);
          vq.push_back($urandom());
        end
        default: begin
          fq.push_back(FN_INT);
          vq.push_back($urandom());
        end
      endcase
    end

    // Damage: replace, drop or insert one item.
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, fq.size() - 1);
      case ($urandom_range(0, 2))
        0: begin
          fq[k] = 3'($urandom_range(0, 7));
          vq[k] = noise_value();
        end
        1: begin
          fq.delete(k);
          vq.delete(k);
        end
        default: begin
          fq.insert(k, 3'($urandom_range(0, 7)));
          vq.insert(k, noise_value());
        end
      endcase
    end
    fq.push_back(FN_END);
    vq.push_back($urandom());

    if (!quiet && $urandom_range(0, 59) == 0)
      hold_req = 1'b1;
    foreach (fq[i])
      send_item(fq[i], vq[i]);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Well-formed message with every argument kind at the reset capacity.
    send_item(FN_ADDR,  32'h0000_00FF);
    send_item(FN_ADDR,  32'h0000_0000);
    send_item(FN_TAG,   with_char(CH_COMMA));
    send_item(FN_TAG,   with_char(CH_F));
    send_item(FN_TAG,   with_char(CH_I));
    send_item(FN_TAG,   with_char(CH_S));
    send_item(FN_TAG,   with_char(CH_NUL));
    send_item(FN_FLOAT, 32'hFFFF_FFFF);
    send_item(FN_INT,   32'h0000_0000);
    send_item(FN_SARG,  with_char(8'h78));
    send_item(FN_SARG,  with_char(CH_NUL));
    send_item(FN_END,   32'hFFFF_FFFF);
    // Tag string without its leading comma.
    send_item(FN_ADDR,  with_char(CH_NUL));
    send_item(FN_TAG,   with_char(CH_S));
    send_item(FN_END,   $urandom());
    // Undefined function code.
    send_item(FN_UNUSED, $urandom());
    send_item(FN_END,   $urandom());
    // Tag character outside s, f and i.
    send_item(FN_ADDR,  with_char(CH_NUL));
    send_item(FN_TAG,   with_char(CH_COMMA));
    send_item(FN_TAG,   with_char(8'h78));
    send_item(FN_END,   $urandom());
    // Argument of the wrong kind.
    send_item(FN_ADDR,  with_char(CH_NUL));
    send_item(FN_TAG,   with_char(CH_COMMA));
    send_item(FN_TAG,   with_char(CH_I));
    send_item(FN_TAG,   with_char(CH_NUL));
    send_item(FN_FLOAT, $urandom());
    send_item(FN_END,   $urandom());
    drain();

    // Zero capacity: the very first byte overflows.
    write_capacity(16'h0000);
    send_item(FN_ADDR, text_char());
    send_item(FN_END,  $urandom());
    drain();

    // Largest capacity, starting with a long hold of the result channel.
    write_capacity(16'hFFFF);
    hold_req = 1'b1;
    while (items_sent < 450)
      send_message();
    drain();

    // Small capacity so that many messages overflow.
    write_capacity(16'($urandom_range(8, 64)));
    while (items_sent < 750)
      send_message();
    drain();

    // Back to the reset value; the last stretch runs without idling.
    write_capacity(CAP_RESET);
    while (items_sent < ITEM_TARGET - 150)
      send_message();
    quiet = 1'b1;
    calm  = 1'b1;
    while (items_sent < ITEM_TARGET)
      send_message();
    drain();

    if (fault_count == 0 && results_owed == 0)
      $display("osc_message_writer_core: match");
    else
      $display("osc_message_writer_core: mismatch");
    $finish;
  end

endmodule
